>>> src/ush_pkg.sv
// Shared widths, constants and status type for the universal string hash block.
`default_nettype none

package ush_pkg;

	localparam int CHAR_W  = 8;
	localparam int COEF_W  = 15;
	localparam int HASH_W  = 13;
	localparam int SIZE_W  = 14;
	localparam int PROD_W  = 2 * COEF_W;

	localparam logic [COEF_W-1:0] SEED_COEFF = 15'd31415;
	localparam logic [COEF_W-1:0] MULT_COEFF = 15'd27183;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 14'd5000;
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 14'd2;
	localparam logic [SIZE_W-1:0] SIZE_MAX   = 14'd8192;

	// Status of a serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} ush_stat_t;

endpackage

`default_nettype wire

>>> src/ush_mul.sv
// Bit-serial shift-and-add multiplier with an added offset, one multiplier bit a cycle.
`default_nettype none

module ush_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ush_pkg::COEF_W-1:0]    mul_a,
	input  wire logic [ush_pkg::COEF_W-1:0]    mul_b,
	input  wire logic [ush_pkg::CHAR_W-1:0]    addend,
	output logic      [ush_pkg::PROD_W-1:0]    product,
	output ush_pkg::ush_stat_t                 stat
);

	localparam int CNT_W = $clog2(ush_pkg::COEF_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ush_pkg::COEF_W - 1);

	logic [ush_pkg::PROD_W-1:0] mcand_q;
	logic [ush_pkg::COEF_W-1:0] mplier_q;
	logic [ush_pkg::PROD_W-1:0] acc_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {{(ush_pkg::PROD_W-ush_pkg::COEF_W){1'b0}}, mul_a};
			mplier_q <= mul_b;
			acc_q    <= {{(ush_pkg::PROD_W-ush_pkg::CHAR_W){1'b0}}, addend};
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[ush_pkg::PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[ush_pkg::COEF_W-1:1]};
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

>>> src/ush_mod.sv
// Bit-serial restoring reduction of a product by a run-time modulus, one dividend bit a cycle.
`default_nettype none

module ush_mod (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ush_pkg::PROD_W-1:0]    dividend,
	input  wire logic [ush_pkg::SIZE_W-1:0]    modulus,
	output logic      [ush_pkg::HASH_W-1:0]    remainder,
	output ush_pkg::ush_stat_t                 stat
);

	localparam int CNT_W = $clog2(ush_pkg::PROD_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ush_pkg::PROD_W - 1);

	logic [ush_pkg::PROD_W-1:0] dvd_q;
	logic [ush_pkg::SIZE_W-1:0] rem_q;
	logic [ush_pkg::SIZE_W-1:0] mod_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [ush_pkg::SIZE_W:0]   trial;
	logic [ush_pkg::SIZE_W:0]   diff;

	// The partial remainder stays below the modulus, so one subtract suffices.
	// A borrow shows in the top bit of the difference when the trial is below the modulus.
	assign trial = {rem_q, dvd_q[ush_pkg::PROD_W-1]};
	assign diff  = trial - {1'b0, mod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			mod_q <= modulus;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ush_pkg::PROD_W-2:0], 1'b0};
			if (!diff[ush_pkg::SIZE_W]) begin
				rem_q <= diff[ush_pkg::SIZE_W-1:0];
			end else begin
				rem_q <= trial[ush_pkg::SIZE_W-1:0];
			end
		end
	end

	assign remainder = rem_q[ush_pkg::HASH_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

>>> src/universal_string_hash.sv
// Top level of the universal string hash: request handshakes, sequencer and serial units.
//
// A key string arrives on the s_axis channel one character per request, the final
// character marked by s_axis_tlast. For every character the coefficient is advanced
// (coefficient * 27183 mod (table size - 1)) and then the character is folded into the
// running hash ((coefficient * hash + character) mod table size). After the final
// character the finished bucket index leaves on the m_axis channel and both values are
// re-seeded for the next key.
// After a character is accepted, s_axis_tready stays low until its hash update is
// done, so no new character is taken before the block is through with the last one;
// for the final character it rises in the same cycle as its result becomes valid.
// The shared bit-serial multiplier and the shared restoring reducer are each used
// twice per character.
// The table size is written through the cfg channel, which is always ready; it is
// clamped into 2..8192 when used and should only be changed while the block is idle.
// Reset restores table size 5000, coefficient 31415 and a zero hash, and empties the
// output register. If the receiver stalls, the result is held in the output register
// and the next key's characters are still accepted; only the completion of a later key
// waits until the held result has been taken.
`default_nettype none

module universal_string_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// cfg_data: table_size [13:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [13:0] cfg_data,
	// s_axis_tdata: char_code [7:0]
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic        s_axis_tlast,
	// m_axis_tdata: hash_value [12:0], zero fill [15:13]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COEF_MUL,
		ST_COEF_MOD,
		ST_HASH_MUL,
		ST_HASH_MOD,
		ST_FINISH
	} state_t;

	state_t                         state_q;
	logic [ush_pkg::SIZE_W-1:0]     table_size_q;
	logic [ush_pkg::COEF_W-1:0]     coef_q;
	logic [ush_pkg::HASH_W-1:0]     hash_q;
	logic [ush_pkg::CHAR_W-1:0]     char_q;
	logic                           last_q;
	logic                           out_valid_q;
	logic [ush_pkg::HASH_W-1:0]     out_hash_q;

	logic                           s_accept;
	logic [ush_pkg::SIZE_W-1:0]     eff_size;
	logic                           mul_start;
	logic [ush_pkg::COEF_W-1:0]     mul_a;
	logic [ush_pkg::COEF_W-1:0]     mul_b;
	logic [ush_pkg::CHAR_W-1:0]     mul_addend;
	logic [ush_pkg::PROD_W-1:0]     mul_product;
	ush_pkg::ush_stat_t             mul_stat;
	logic                           mod_start;
	logic [ush_pkg::SIZE_W-1:0]     mod_n;
	logic [ush_pkg::HASH_W-1:0]     mod_rem;
	ush_pkg::ush_stat_t             mod_stat;
	logic                           out_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE) && !mul_stat.busy && !mod_stat.busy;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Register values outside the supported range are clamped.
	always_comb begin
		if (table_size_q < ush_pkg::SIZE_MIN) begin
			eff_size = ush_pkg::SIZE_MIN;
		end else if (table_size_q > ush_pkg::SIZE_MAX) begin
			eff_size = ush_pkg::SIZE_MAX;
		end else begin
			eff_size = table_size_q;
		end
	end

	// The multiplier first advances the coefficient, then forms coefficient * hash plus
	// the character; the new coefficient is taken straight from the reducer output.
	always_comb begin
		if (state_q == ST_IDLE) begin
			mul_a      = coef_q;
			mul_b      = ush_pkg::MULT_COEFF;
			mul_addend = '0;
		end else begin
			mul_a      = {{(ush_pkg::COEF_W-ush_pkg::HASH_W){1'b0}}, mod_rem};
			mul_b      = {{(ush_pkg::COEF_W-ush_pkg::HASH_W){1'b0}}, hash_q};
			mul_addend = char_q;
		end
	end

	assign mul_start = s_accept || ((state_q == ST_COEF_MOD) && mod_stat.done);
	assign mod_start = mul_stat.done;
	assign mod_n     = (state_q == ST_COEF_MUL) ? (eff_size - 1'b1) : eff_size;

	ush_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.addend  (mul_addend),
		.product (mul_product),
		.stat    (mul_stat)
	);

	ush_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mul_product),
		.modulus   (mod_n),
		.remainder (mod_rem),
		.stat      (mod_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			table_size_q <= ush_pkg::SIZE_RESET;
			coef_q       <= ush_pkg::SEED_COEFF;
			hash_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				table_size_q <= cfg_data;
			end
			// A finished key loads the output register; otherwise a taken result empties it.
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_COEF_MUL;
					end
				end
				ST_COEF_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_COEF_MOD;
					end
				end
				ST_COEF_MOD: begin
					if (mod_stat.done) begin
						coef_q  <= {{(ush_pkg::COEF_W-ush_pkg::HASH_W){1'b0}}, mod_rem};
						state_q <= ST_HASH_MUL;
					end
				end
				ST_HASH_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_HASH_MOD;
					end
				end
				ST_HASH_MOD: begin
					if (mod_stat.done) begin
						hash_q  <= mod_rem;
						state_q <= last_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_FINISH: begin
					// Wait here only while an earlier result is still held.
					if (out_free) begin
						coef_q      <= ush_pkg::SEED_COEFF;
						hash_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			char_q <= s_axis_tdata;
			last_q <= s_axis_tlast;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			out_hash_q <= hash_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(16-ush_pkg::HASH_W){1'b0}}, out_hash_q};

endmodule

`default_nettype wire

>>> src/ush_checker.sv
// Port-level assertions for the universal string hash, bound to its top level.
`default_nettype none

module ush_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	// A bucket index never reaches the upper fill bits.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:13] == 3'b000))
		else $error("hash value beyond largest table size");

	// A character keeps the block busy for the following cycle.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready straight after a request");

	// A character that does not end its key produces no result.
	a_no_result_mid_key: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid))
		else $error("result raised by a character that is not the last");

	// The configuration channel never stalls.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind universal_string_hash ush_checker u_ush_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
